// ===== design/dart_pkg.sv =====
// dart_pkg: shared types, register indexes and a constant table for the
// divider and reload timer. No dependencies.
package dart_pkg;

  localparam int TicksW   = 8;
  localparam int LowW     = 10;   // cycle counter width, spans the widest timer period
  localparam int CntW     = 8;
  localparam int CfgAddrW = 2;
  localparam int CfgDataW = 8;
  localparam int InDataW  = 8;
  localparam int OutDataW = 24;   // 17 bits of fields, padded to bytes

  localparam logic [CfgAddrW-1:0] CFG_RELOAD = 2'd0;
  localparam logic [CfgAddrW-1:0] CFG_ENABLE = 2'd1;
  localparam logic [CfgAddrW-1:0] CFG_CLKSEL = 2'd2;

  localparam logic [1:0] SEL_1024 = 2'd0;
  localparam logic [1:0] SEL_16   = 2'd1;
  localparam logic [1:0] SEL_64   = 2'd2;
  localparam logic [1:0] SEL_256  = 2'd3;

  typedef struct packed {
    logic [CntW-1:0] reload;
    logic            enable;
    logic [1:0]      clk_sel;
  } cfg_t;

  typedef struct packed {
    logic [LowW-1:0] cycle_low;
    logic [CntW-1:0] divider;
    logic [CntW-1:0] timer;
  } state_t;

  // m mod p for m in 0..15 and p in 1..16; index {p[3:0], m}, p code 0 is 16
  function automatic logic [255:0][3:0] mod_tbl_build();
    logic [255:0][3:0] tbl;
    int per;
    int v;
    tbl = '0;
    for (int p = 0; p < 16; p++) begin
      per = (p == 0) ? 16 : p;
      for (int m = 0; m < 16; m++) begin
        v = m;
        for (int k = 0; k < 16; k++) begin
          if (v >= per) v = v - per;
        end
        tbl[p*16 + m] = 4'(v);
      end
    end
    return tbl;
  endfunction

  localparam logic [255:0][3:0] MOD_TBL = mod_tbl_build();

endpackage

// ===== design/dart_step.sv =====
// dart_step: next-state logic for one beat of elapsed ticks.
// Depends on dart_pkg.
module dart_step (
  input  dart_pkg::state_t                cur_i,
  input  dart_pkg::cfg_t                  cfg_i,
  input  logic [dart_pkg::TicksW-1:0]     ticks_i,
  output dart_pkg::state_t                nxt_o,
  output logic                            irq_o
);

  logic [8:0]  sum4, sum6, sum8;
  logic [10:0] sum10;
  logic [4:0]  n_cross;
  logic [8:0]  tsum;
  logic [3:0]  rem_raw;
  logic [3:0]  rem;
  logic [3:0]  per_code;
  logic        short_per;
  logic        ovf;

  assign sum4  = {1'b0, ticks_i} + {5'd0, cur_i.cycle_low[3:0]};
  assign sum6  = {1'b0, ticks_i} + {3'd0, cur_i.cycle_low[5:0]};
  assign sum8  = {1'b0, ticks_i} + {1'b0, cur_i.cycle_low[7:0]};
  assign sum10 = {3'd0, ticks_i} + {1'b0, cur_i.cycle_low};

  always_comb begin
    unique case (cfg_i.clk_sel)
      dart_pkg::SEL_1024: n_cross = {4'd0, sum10[10]};
      dart_pkg::SEL_16:   n_cross = sum4[8:4];
      dart_pkg::SEL_64:   n_cross = {2'd0, sum6[8:6]};
      dart_pkg::SEL_256:  n_cross = {4'd0, sum8[8]};
      default:            n_cross = '0;
    endcase
    if (!cfg_i.enable) n_cross = '0;
  end

  // n_cross <= 16: at most one wrap of tsum; MOD_TBL folds repeat wraps of short periods
  assign tsum      = {1'b0, cur_i.timer} + {4'd0, n_cross};
  assign ovf       = tsum[8];
  assign short_per = (cfg_i.reload[7:4] == 4'hF) && (cfg_i.reload[3:0] != 4'h0);
  assign per_code  = 4'(5'd16 - {1'b0, cfg_i.reload[3:0]});
  assign rem_raw   = dart_pkg::MOD_TBL[{per_code, tsum[3:0]}];
  assign rem       = short_per ? rem_raw : tsum[3:0];

  assign nxt_o.cycle_low = sum10[9:0];
  assign nxt_o.divider   = cur_i.divider + {7'd0, sum8[8]};
  assign nxt_o.timer     = ovf ? (cfg_i.reload + {4'd0, rem}) : tsum[7:0];
  assign irq_o           = ovf;

endmodule

// ===== design/divider_and_reload_timer.sv =====
// divider_and_reload_timer: top level, config registers, state and output
// register. Depends on dart_pkg and dart_step.
//
// Each input beat carries a count of elapsed clock cycles (0..255). The block
// advances its cycle counter, bumps the free-running divider on each low-byte
// carry and, when enabled, advances the timer by the number of selected
// period boundaries crossed, reloading on every pass beyond 255 and flagging
// timer_irq. One beat is accepted per clock unless the output stalls; its
// result appears in the output register on the next cycle. The single output
// register sets the rate: new beats enter while it is empty or being drained.
// Registers: 0 reload_value, 1 timer_enable, 2 clock_select; write only
// while idle.
module divider_and_reload_timer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dart_pkg::CfgAddrW-1:0]     cfg_addr_i,
  input  logic [dart_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [dart_pkg::InDataW-1:0]      s_axis_tdata,   // [7:0] ticks
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [7:0] divider, [15:8] timer_count, [16] timer_irq, [23:17] zero
  output logic [dart_pkg::OutDataW-1:0]     m_axis_tdata
);

  dart_pkg::cfg_t   cfg_q;
  dart_pkg::state_t st_q, st_d;
  logic             irq_d;
  logic             out_vld_q;
  logic [16:0]      out_q;
  logic             in_beat;

  assign s_axis_tready = !out_vld_q || m_axis_tready;
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        dart_pkg::CFG_RELOAD: cfg_q.reload  <= cfg_wdata_i;
        dart_pkg::CFG_ENABLE: cfg_q.enable  <= cfg_wdata_i[0];
        dart_pkg::CFG_CLKSEL: cfg_q.clk_sel <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  dart_step u_step (
    .cur_i   (st_q),
    .cfg_i   (cfg_q),
    .ticks_i (s_axis_tdata[dart_pkg::TicksW-1:0]),
    .nxt_o   (st_d),
    .irq_o   (irq_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_beat) begin
        st_q      <= st_d;
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) out_q <= {irq_d, st_d.timer, st_d.divider};
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, out_q};

endmodule

// ===== design/dart_checker.sv =====
// dart_checker: port-level checks for divider_and_reload_timer, bound to
// the top level. Depends on divider_and_reload_timer's ports only.
module dart_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  // result beat held while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result beat changed");

  // every accepted input beat shows up as a result next cycle
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted beat produced no result");

  // no input taken while the output register is full and stalled
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted over a stalled result");

  // no result appears without an accepted input
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid && !(s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid)
    else $error("result beat without input");

endmodule

bind divider_and_reload_timer dart_checker u_dart_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: self-checking testbench for divider_and_reload_timer; a scoreboard class
// predicts divider, timer and irq per tick beat. Depends on dart_pkg and the block.
module tb_top;
  import dart_pkg::*;

  localparam int IdleLimit = 2000;
  localparam int PhaseItems = 150;
  localparam int NumPhases = 12;
  localparam logic [CfgAddrW-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic       irq;
    logic [7:0] timer;
    logic [7:0] divider;
  } timer_beat_t;

  class timer_scoreboard;
    logic [7:0]  reload = '0;
    logic        enable = 1'b0;
    logic [1:0]  clk_sel = SEL_1024;
    logic [31:0] cycles = '0;
    logic [7:0]  divider = '0;
    logic [7:0]  timer = '0;
    timer_beat_t expected_beats[$];
    int          errors = 0;

    function void write_reg(logic [CfgAddrW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        CFG_RELOAD: reload = val;
        CFG_ENABLE: enable = val[0];
        CFG_CLKSEL: clk_sel = val[1:0];
        default: ;
      endcase
    endfunction

    function void note_ticks(logic [7:0] ticks);
      logic [32:0] prev;
      logic [32:0] sum;
      int shift;
      int steps;
      timer_beat_t beat;
      prev = {1'b0, cycles};
      sum = prev + ticks;
      beat.irq = 1'b0;
      if (sum[32:8] != prev[32:8]) divider = divider + 8'd1;
      if (enable) begin
        case (clk_sel)
          SEL_1024: shift = 10;
          SEL_16:   shift = 4;
          SEL_64:   shift = 6;
          default:  shift = 8;
        endcase
        steps = int'((sum >> shift) - (prev >> shift));
        repeat (steps) begin
          if (timer == 8'hFF) begin
            timer = reload;
            beat.irq = 1'b1;
          end else begin
            timer = timer + 8'd1;
          end
        end
      end
      cycles = sum[31:0];
      beat.divider = divider;
      beat.timer = timer;
      expected_beats.push_back(beat);
    endfunction

    function void check_beat(logic [OutDataW-1:0] data);
      timer_beat_t got;
      timer_beat_t exp;
      got = timer_beat_t'(data[16:0]);
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, data);
        errors++;
        return;
      end
      exp = expected_beats.pop_front();
      if (got.divider !== exp.divider) begin
        $display("%0t: divider expected %0d actual %0d", $time, exp.divider, got.divider);
        errors++;
      end
      if (got.timer !== exp.timer) begin
        $display("%0t: timer_count expected %0d actual %0d", $time, exp.timer, got.timer);
        errors++;
      end
      if (got.irq !== exp.irq) begin
        $display("%0t: timer_irq expected %0d actual %0d", $time, exp.irq, got.irq);
        errors++;
      end
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  timer_scoreboard sb = new();
  bit calm = 1'b0;
  int rx_hold = 0;
  int rx_stall = 0;
  int idle_cycles = 0;

  divider_and_reload_timer dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_addr_i,
    .cfg_wdata_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] draw_ticks();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom_range(0, 15));
      3: return 8'($urandom_range(240, 255));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // beat monitors and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_ticks(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_beat(m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // receiver: random stalls outside the calm phases, with a long hold-off in phase 2
  initial begin
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        m_axis_tready <= 1'b0;
        rx_hold--;
      end else if (rx_stall > 0) begin
        m_axis_tready <= 1'b0;
        rx_stall--;
      end else begin
        m_axis_tready <= 1'b1;
        rx_stall = calm ? 0 : draw_gap();
      end
    end
  end

  task automatic send_ticks(input logic [7:0] ticks);
    int gap;
    gap = calm ? 0 : draw_gap();
    if (gap > 0) begin
      @(negedge clk_i) s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= ticks;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_idle();
    @(negedge clk_i) s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgAddrW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
    @(negedge clk_i) cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [1:0] sel_order[4];
    logic [7:0] reload;
    sel_order = '{SEL_1024, SEL_16, SEL_64, SEL_256};
    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // timer disabled at reset: divider moves, timer holds
    send_ticks(8'd0);
    send_ticks(8'd255);
    send_ticks(8'd1);
    wait_idle();
    cfg_write(CFG_UNUSED, 8'h55);
    cfg_write(CFG_RELOAD, 8'hFE);
    cfg_write(CFG_ENABLE, 8'hFF);
    cfg_write(CFG_CLKSEL, CfgDataW'(SEL_16));
    // ~16 increments per beat; reload 0xFE gives repeated overflow within a beat
    repeat (20) send_ticks(8'd255);
    wait_idle();

    for (int ph = 0; ph < NumPhases; ph++) begin
      calm = (ph == 2 || ph == 7);
      if (ph == 2) rx_hold = 300;
      reload = (ph == 0) ? 8'h00 : (ph == 1) ? 8'hFF : 8'($urandom_range(0, 255));
      cfg_write(CFG_RELOAD, reload);
      cfg_write(CFG_ENABLE, (ph == 4) ? 8'h00 : (ph == 9) ? 8'hFE : 8'h01);
      cfg_write(CFG_CLKSEL, CfgDataW'(sel_order[ph % 4]));
      repeat (PhaseItems) send_ticks(draw_ticks());
      wait_idle();
    end

    repeat (10) @(posedge clk_i);
    if (sb.pending() != 0) sb.errors++;
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
